// ===== hw/rtl/mtprng_pkg.sv =====
// ----------------------------------------------------------------------------
// mtprng_pkg: shared types and constants of the MT19937 generator
// Holds table geometry, tempering constants, controller commands and status.
// ----------------------------------------------------------------------------
`default_nettype none
package mtprng_pkg;
	localparam int unsigned TableWords  = 624;
	localparam int unsigned TwistOffset = 397;
	localparam int unsigned AddrW       = 10;

	localparam logic [31:0] SeedMult  = 32'h6c078965;
	localparam logic [31:0] TwistXor  = 32'h9908b0df;
	localparam logic [31:0] TemperB   = 32'h9d2c5680;
	localparam logic [31:0] TemperC   = 32'hefc60000;
	localparam logic [31:0] SeedReset = 32'd5489;

	localparam logic [AddrW-1:0] LastAddr    = AddrW'(TableWords - 1);
	localparam logic [AddrW-1:0] EndAddr     = AddrW'(TableWords);
	localparam logic [AddrW-1:0] OffsetAddr  = AddrW'(TwistOffset);
	localparam logic [AddrW-1:0] WrapAddr    = AddrW'(TableWords - TwistOffset);

	typedef logic [AddrW-1:0] addr_t;

	typedef enum logic [1:0] {
		ACT_RESEED = 2'd0,
		ACT_RAW    = 2'd1,
		ACT_RANGE  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic seed_init;   // load seed into word 0, start rebuild
		logic seed_step;   // one phase of rebuilding a word
		logic twist_start; // begin one pass
		logic twist_step;  // one phase of twisting a word
		logic fetch;       // read word at position
		logic temper;      // temper fetched word, advance position
		logic div_start;   // start modulo
		logic div_step;    // one modulo bit
		logic finish;      // form result
	} dp_cmd_t;

	typedef struct packed {
		logic seed_done;
		logic twist_done;
		logic pos_end;
		logic div_done;
	} dp_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mtprng_datapath.sv =====
// ----------------------------------------------------------------------------
// mtprng_datapath: state table, seeding, twist, tempering and modulo
// Table memory with one write port and one registered read port; words are handled one at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module mtprng_datapath (
	input  wire                    clk,
	input  wire                    arst_n,
	input  mtprng_pkg::dp_cmd_t    cmd,
	output mtprng_pkg::dp_sts_t    sts,
	input  wire  [31:0]            seed_reg,
	input  wire  [1:0]             act,
	input  wire  [31:0]            lo,
	input  wire  [31:0]            hi,
	output logic [31:0]            res_value,
	output logic                   res_bad
);
	import mtprng_pkg::*;

	logic [31:0] mem [TableWords];
	logic [31:0] rd_q;
	addr_t       pos_q;
	addr_t       idx_q;
	logic [1:0]  ph_q;
	logic [31:0] prev_q, cur_q, mult_q, word_q;
	logic [31:0] rem_q, quo_q, span_q;
	logic [5:0]  dcnt_q;
	logic        full_q;

	addr_t       rd_addr, wr_addr;
	logic        wr_en;
	logic [31:0] wr_data, mixed, twisted, t1, t2, t3, t4;
	logic [32:0] rem_sh;
	logic [31:0] span_c;
	addr_t       idx_p1, idx_off;

	assign idx_p1  = (idx_q == LastAddr) ? '0 : idx_q + 1'b1;
	assign idx_off = (idx_q >= WrapAddr) ? idx_q - WrapAddr : idx_q + OffsetAddr;
	assign mixed   = {cur_q[31], prev_q[30:0]};
	assign twisted = rd_q ^ {1'b0, mixed[31:1]} ^ (mixed[0] ? TwistXor : 32'd0);

	// Twist word phases: 0 read k, 1 read k+1, 2 read k+m, 3 write
	always_comb begin
		rd_addr = pos_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = mult_q + {22'd0, idx_q};
		if (cmd.seed_init) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = seed_reg;
		end else if (cmd.seed_step && ph_q == 2'd1) begin
			wr_en = 1'b1;
		end else if (cmd.twist_step) begin
			unique case (ph_q)
				2'd0: rd_addr = idx_q;
				2'd1: rd_addr = idx_p1;
				2'd2: rd_addr = idx_off;
				default: begin
					wr_en   = 1'b1;
					wr_data = twisted;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign t1 = word_q ^ (word_q >> 11);
	assign t2 = t1 ^ ((t1 << 7) & TemperB);
	assign t3 = t2 ^ ((t2 << 15) & TemperC);
	assign t4 = t3 ^ (t3 >> 18);
	assign span_c = hi - lo + 32'd1;
	assign rem_sh = {rem_q, quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= EndAddr;
			idx_q  <= '0;
			ph_q   <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.seed_init) begin
				idx_q <= AddrW'(1);
				ph_q  <= '0;
				pos_q <= EndAddr;
			end else if (cmd.seed_step) begin
				ph_q <= ph_q ^ 2'd1;
				if (ph_q == 2'd1) idx_q <= idx_q + 1'b1;
			end else if (cmd.twist_start) begin
				idx_q <= '0;
				ph_q  <= '0;
			end else if (cmd.twist_step) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					idx_q <= idx_p1;
					if (idx_q == LastAddr) pos_q <= '0;
				end
			end
			if (cmd.temper) pos_q <= pos_q + 1'b1;
			if (cmd.div_start) dcnt_q <= 6'd32;
			else if (cmd.div_step) dcnt_q <= dcnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_init) prev_q <= seed_reg;
		else if (cmd.seed_step) begin
			if (ph_q == 2'd0) mult_q <= SeedMult * (prev_q ^ (prev_q >> 30));
			else prev_q <= mult_q + {22'd0, idx_q};
		end
		if (cmd.twist_step) begin
			if (ph_q == 2'd1) cur_q <= rd_q;
			if (ph_q == 2'd2) prev_q <= rd_q;
		end
		if (cmd.temper) word_q <= rd_q;
		if (cmd.div_start) begin
			span_q <= span_c;
			full_q <= (span_c == 32'd0);
			quo_q  <= t4;
			rem_q  <= '0;
			word_q <= t4;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (rem_sh >= {1'b0, span_q}) rem_q <= 32'(rem_sh - {1'b0, span_q});
			else rem_q <= rem_sh[31:0];
		end
		if (cmd.finish) begin
			res_bad   <= 1'b0;
			res_value <= '0;
			case (act)
				ACT_RAW:   res_value <= t4;
				ACT_RANGE: begin
					if (lo > hi) res_bad <= 1'b1;
					else res_value <= full_q ? word_q : lo + rem_q;
				end
				default: ;
			endcase
		end
	end

	// twist holds word k+1 in prev_q from phase 2; at phase 3 rd_q holds word k+m
	assign sts.seed_done  = cmd.seed_step && ph_q == 2'd1 && idx_q == LastAddr;
	assign sts.twist_done = cmd.twist_step && ph_q == 2'd3 && idx_q == LastAddr;
	assign sts.pos_end    = (pos_q >= EndAddr);
	assign sts.div_done   = (dcnt_q == 6'd0);
endmodule
`default_nettype wire

// ===== hw/rtl/mtprng_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtprng_ctrl: sequencer of the generator
// Walks reset rebuild, reseed, twist, fetch, tempering and modulo steps.
// ----------------------------------------------------------------------------
`default_nettype none
module mtprng_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire  [1:0]           action,
	input  wire  [31:0]          range_low,
	input  wire  [31:0]          range_high,
	output logic                 busy,
	output logic                 done,
	output logic [1:0]           act_q,
	output logic [31:0]          lo_q,
	output logic [31:0]          hi_q,
	output mtprng_pkg::dp_cmd_t  cmd,
	input  mtprng_pkg::dp_sts_t  sts
);
	import mtprng_pkg::*;

	typedef enum logic [10:0] {
		S_INIT   = 11'b00000000001,
		S_SEED   = 11'b00000000010,
		S_IDLE   = 11'b00000000100,
		S_DECIDE = 11'b00000001000,
		S_TWST0  = 11'b00000010000,
		S_TWIST  = 11'b00000100000,
		S_FETCH  = 11'b00001000000,
		S_TEMP   = 11'b00010000000,
		S_DIV    = 11'b00100000000,
		S_DIVRUN = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   reset_seed_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.seed_init = 1'b1;
				state_d = S_SEED;
			end
			S_SEED: begin
				cmd.seed_step = 1'b1;
				if (sts.seed_done) state_d = reset_seed_q ? S_IDLE : S_DONE;
			end
			S_IDLE: if (start) state_d = S_DECIDE;
			S_DECIDE: begin
				if (act_q == ACT_RESEED) state_d = S_INIT;
				else if (act_q == ACT_RAW || (act_q == ACT_RANGE && lo_q <= hi_q))
					state_d = sts.pos_end ? S_TWST0 : S_FETCH;
				else state_d = S_DONE;
			end
			S_TWST0: begin
				cmd.twist_start = 1'b1;
				state_d = S_TWIST;
			end
			S_TWIST: begin
				cmd.twist_step = 1'b1;
				if (sts.twist_done) state_d = S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = S_TEMP;
			end
			S_TEMP: begin
				cmd.temper = 1'b1;
				state_d = (act_q == ACT_RANGE) ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = S_DIVRUN;
			end
			S_DIVRUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.div_step = 1'b0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			reset_seed_q <= 1'b1;
			done         <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= cmd.finish;
			if (state_q == S_DECIDE) reset_seed_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q <= action;
			lo_q  <= range_low;
			hi_q  <= range_high;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ===== hw/rtl/mersenne_twister_prng_core.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_prng_core: MT19937 32-bit random word generator
// Reseed, raw draws and bounded draws over a 624-word state table.
// ----------------------------------------------------------------------------
//  channel   | signals                              | transfer
//  ----------+--------------------------------------+---------------------------
//  command   | start, busy, action, range_low/high  | start & !busy
//  result    | done, value, bad_range               | done, one cycle
//  seed reg  | seed_we, seed_wdata                  | seed_we
//
//  A draw runs a twist pass over the whole table first when one is due;
//  a range draw adds a bit-serial modulo; a reseed rebuilds the table.
//  Reset rebuilds the table from seed 5489, with busy high.
//  A transaction is held in busy until done; done cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module mersenne_twister_prng_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  action,
	input  wire  [31:0] range_low,
	input  wire  [31:0] range_high,
	output logic        done,
	output logic [31:0] value,
	output logic        bad_range,
	input  wire         seed_we,
	input  wire  [31:0] seed_wdata
);
	import mtprng_pkg::*;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [31:0] seed_q, lo_q, hi_q;
	logic [1:0]  act_q;

	// Seed register: picked up on the next reseed only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= SeedReset;
		else if (seed_we) seed_q <= seed_wdata;
	end

	mtprng_ctrl u_ctrl (
		.clk, .arst_n, .start, .action, .range_low, .range_high,
		.busy, .done, .act_q, .lo_q, .hi_q, .cmd, .sts
	);

	mtprng_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .seed_reg(seed_q),
		.act(act_q), .lo(lo_q), .hi(hi_q),
		.res_value(value), .res_bad(bad_range)
	);
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the MT19937 generator core
// Drives reseeds, raw draws, bounded draws and unused codes, predicts every
// result with a local twister model and compares each done strobe in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import mtprng_pkg::*;

	localparam string PassMsg = "No mismatches found";

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [31:0] range_low;
	logic [31:0] range_high;
	logic        done;
	logic [31:0] value;
	logic        bad_range;
	logic        seed_we;
	logic [31:0] seed_wdata;

	typedef struct packed {
		logic [31:0] value;
		logic        bad_range;
	} draw_result_t;

	// Local copy of the generator state
	logic [31:0]  pred_seed;
	logic [31:0]  pred_table [TableWords];
	int unsigned  pred_pos;
	draw_result_t pending_draws [$];

	int unsigned error_count;
	int unsigned sent_count;
	int unsigned checked_count;
	int unsigned send_gap_pct;

	mersenne_twister_prng_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.range_low  (range_low),
		.range_high (range_high),
		.done       (done),
		.value      (value),
		.bad_range  (bad_range),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Rebuild the whole table from the held seed
	task automatic rebuild_words();
		logic [31:0] prev;
		pred_table[0] = pred_seed;
		for (int k = 1; k < TableWords; k++) begin
			prev = pred_table[k-1];
			pred_table[k] = SeedMult * (prev ^ (prev >> 30)) + 32'(k);
		end
		pred_pos = TableWords;
	endtask

	task automatic twist_words();
		logic [31:0] mixed;
		logic [31:0] nxt;
		for (int k = 0; k < TableWords; k++) begin
			mixed = (pred_table[k] & 32'h80000000) |
				(pred_table[(k + 1) % TableWords] & 32'h7fffffff);
			nxt = pred_table[(k + TwistOffset) % TableWords] ^ (mixed >> 1);
			if (mixed[0])
				nxt ^= TwistXor;
			pred_table[k] = nxt;
		end
		pred_pos = 0;
	endtask

	task automatic next_tempered(output logic [31:0] y);
		if (pred_pos >= TableWords)
			twist_words();
		y = pred_table[pred_pos];
		pred_pos++;
		y ^= y >> 11;
		y ^= (y << 7) & TemperB;
		y ^= (y << 15) & TemperC;
		y ^= y >> 18;
	endtask

	// Work out the result that one command causes and advance the local state
	task automatic predict_draw(input logic [1:0] act, input logic [31:0] lo,
			input logic [31:0] hi, output draw_result_t res);
		logic [31:0] span;
		logic [31:0] w;
		res = '0;
		case (act)
			ACT_RESEED: begin
				rebuild_words();
			end
			ACT_RAW: begin
				next_tempered(w);
				res.value = w;
			end
			ACT_RANGE: begin
				if (lo > hi) begin
					res.bad_range = 1'b1;
				end else begin
					span = hi - lo + 32'd1;
					next_tempered(w);
					res.value = (span == 0) ? w : lo + (w % span);
				end
			end
			default: begin
			end
		endcase
	endtask

	// Send one transaction: optional idle gap, then hold start until accepted
	task automatic send_cmd(input logic [1:0] act, input logic [31:0] lo,
			input logic [31:0] hi);
		draw_result_t res;
		while ($urandom_range(99) < send_gap_pct)
			@(posedge clk);
		start      <= 1'b1;
		action     <= act;
		range_low  <= lo;
		range_high <= hi;
		do
			@(posedge clk);
		while (busy);
		predict_draw(act, lo, hi, res);
		pending_draws.push_back(res);
		sent_count++;
		start      <= 1'b0;
		action     <= 2'($urandom);
		range_low  <= $urandom;
		range_high <= $urandom;
		// Drop start and scramble the other inputs; the core is busy with this command
		@(posedge clk);
	endtask

	// Wait for every outstanding result, then let the core settle
	task automatic wait_idle();
		int unsigned guard;
		guard = 0;
		while (pending_draws.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] s);
		wait_idle();
		seed_we    <= 1'b1;
		seed_wdata <= s;
		@(posedge clk);
		seed_we    <= 1'b0;
		seed_wdata <= $urandom;
		pred_seed = s;
	endtask

	// Compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && done) begin
			if (pending_draws.size() == 0) begin
				$error("unexpected result: value %h bad_range %b", value, bad_range);
				error_count++;
			end else begin
				want = pending_draws.pop_front();
				checked_count++;
				if (value !== want.value) begin
					$error("value: expected %h, got %h", want.value, value);
					error_count++;
				end
				if (bad_range !== want.bad_range) begin
					$error("bad_range: expected %b, got %b", want.bad_range, bad_range);
					error_count++;
				end
			end
		end
	end

	// Edges of the fields, every action, bad and full ranges, seed latching
	task automatic test_directed();
		send_cmd(ACT_RAW, 32'd0, 32'd0);
		send_cmd(ACT_RAW, 32'hffffffff, 32'hffffffff);
		send_cmd(ACT_RANGE, 32'd0, 32'hffffffff);
		send_cmd(ACT_RANGE, 32'd5, 32'd5);
		send_cmd(ACT_RANGE, 32'd0, 32'd0);
		send_cmd(ACT_RANGE, 32'hffffffff, 32'hffffffff);
		send_cmd(ACT_RANGE, 32'd10, 32'd3);
		send_cmd(ACT_RANGE, 32'hffffffff, 32'd0);
		send_cmd(ACT_RANGE, 32'd1, 32'hffffffff);
		send_cmd(ACT_RANGE, 32'd0, 32'hfffffffe);
		send_cmd(ACT_RANGE, 32'd100, 32'd199);
		send_cmd(ACT_NONE, 32'hffffffff, 32'hffffffff);
		send_cmd(ACT_RESEED, 32'hffffffff, 32'd0);
		send_cmd(ACT_RAW, 32'd0, 32'd0);
		// Seed takes effect only at the next reseed
		write_seed(32'd0);
		send_cmd(ACT_RAW, 32'd0, 32'd0);
		send_cmd(ACT_RESEED, 32'd0, 32'd0);
		send_cmd(ACT_RAW, 32'd0, 32'd0);
		write_seed(32'hffffffff);
		send_cmd(ACT_RESEED, 32'd0, 32'd0);
		send_cmd(ACT_RANGE, 32'd0, 32'd1);
		send_cmd(ACT_RAW, 32'd0, 32'd0);
	endtask

	// Mostly draws with random bounds; the odd reseed and unused code
	task automatic test_random(input int unsigned count);
		logic [1:0]  act;
		logic [31:0] lo;
		logic [31:0] hi;
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			lo = $urandom;
			hi = $urandom;
			if (pick < 2)
				act = ACT_RESEED;
			else if (pick < 5)
				act = ACT_NONE;
			else if (pick < 45)
				act = ACT_RAW;
			else begin
				act = ACT_RANGE;
				case ($urandom_range(3))
					0: hi = lo + 32'($urandom_range(255));
					1: begin
						lo = $urandom_range(15);
						hi = 32'hffffffff - $urandom_range(3);
					end
					default: begin
					end
				endcase
			end
			send_cmd(act, lo, hi);
		end
	endtask

	// Seed changes between phases, each followed by a reseed
	task automatic test_reseeds();
		write_seed(32'd5489);
		send_cmd(ACT_RESEED, 32'd0, 32'd0);
		test_random(40);
		write_seed($urandom);
		send_cmd(ACT_RESEED, 32'd0, 32'd0);
		test_random(40);
	endtask

	initial begin
		error_count   = 0;
		sent_count    = 0;
		checked_count = 0;
		send_gap_pct  = 0;
		pred_seed     = SeedReset;
		rebuild_words();
		arst_n     = 1'b0;
		start      = 1'b0;
		action     = ACT_RAW;
		range_low  = '0;
		range_high = '0;
		seed_we    = 1'b0;
		seed_wdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		send_gap_pct = 36;
		test_random(320);
		send_gap_pct = 66;
		test_random(320);
		send_gap_pct = 0;
		test_reseeds();
		test_random(300);
		wait_idle();
		repeat (50) @(posedge clk);

		$display("Sent %0d commands, checked %0d results", sent_count, checked_count);
		$display("Covered reseeds, raw and bounded draws, bad and full ranges");
		if (error_count == 0 && pending_draws.size() == 0) begin
			$display(PassMsg);
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Reseeds and twists dominate the run time of the 1042 commands
	initial begin
		#200000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
